[design/cswg_pkg.sv]
// ----------------------------------------------------------------------------
// cswg_pkg
// Shared widths, stream layout and stage control types for the cubic
// B-spline weight and gradient pipeline.
// ----------------------------------------------------------------------------
package cswg_pkg;

  localparam int NUM_AXES    = 3;
  localparam int COORD_W     = 19;
  localparam int WEIGHT_W    = 17;
  localparam int GRAD_W      = 18;

  localparam int IN_DATA_W   = 64;
  localparam int OUT_DATA_W  = 72;

  // register stages inside one axis lane, then in the combine unit
  localparam int AXIS_STAGES = 5;
  localparam int COMB_STAGES = 2;
  localparam int NUM_STAGES  = AXIS_STAGES + COMB_STAGES;

  typedef struct packed {
    logic [AXIS_STAGES-1:0] en;
  } axis_ctl_t;

  typedef struct packed {
    logic [COMB_STAGES-1:0] en;
  } comb_ctl_t;

endpackage

[design/cswg_axis.sv]
// ----------------------------------------------------------------------------
// cswg_axis
// One axis lane: magnitude, support test, spline value and derivative
// magnitude over five register stages.
// ----------------------------------------------------------------------------
module cswg_axis
  import cswg_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic                       clk,
  input  axis_ctl_t                  ctl,
  input  logic signed [COORD_W-1:0]  coord,
  output logic [FRACTION_BITS+1:0]   val,
  output logic [FRACTION_BITS+1:0]   mag,
  output logic                       neg,
  output logic                       outside
);

  localparam int F  = FRACTION_BITS;
  localparam int FW = F + 2;
  localparam int LW = (FW > COORD_W) ? FW : COORD_W;

  localparam logic [FW-1:0]   ONE     = {{(FW-1){1'b0}}, 1'b1} << F;
  localparam logic [FW-1:0]   HALF    = ONE >> 1;
  localparam logic [FW-1:0]   TWO_ONE = ONE << 1;
  localparam logic [2*FW-1:0] RND     = {{(2*FW-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [2*FW:0]   RECIP_W = ({{(2*FW){1'b0}}, 1'b1} << (FW + 1)) / 3 + 1;
  localparam logic [FW-1:0]   RECIP   = RECIP_W[FW-1:0];

  function automatic logic [FW-1:0] fx_mul(input logic [FW-1:0] a, input logic [FW-1:0] b);
    logic [2*FW-1:0] p;
    p = {{FW{1'b0}}, a} * {{FW{1'b0}}, b} + RND;
    return p[F +: FW];
  endfunction

  // stage 0
  logic [COORD_W-1:0] vabs;
  logic [FW-1:0]      v0, w0;
  logic               low0, neg0, out0;

  // stage 1
  logic [FW-1:0]      sq1, maglo1, w1;
  logic               low1, neg1, out1;

  // stage 2
  logic [FW-1:0]      pt2, mag2;
  logic               low2, neg2, out2;

  // stage 3
  logic [FW-1:0]      num3, mag3;
  logic               neg3, out3;

  // stage 4
  logic [FW-1:0]      val4, mag4;
  logic               neg4, out4;

  logic [FW-1:0]      v_in, a_sel, b_lo;
  logic [FW+3:0]      p12;
  logic [FW-1:0]      num_lo, num_next;
  logic [2*FW-1:0]    quot_prod;

  always_comb begin
    vabs      = coord[COORD_W-1] ? (~coord + 1'b1) : coord;
    v_in      = FW'(vabs);
    a_sel     = low0 ? v0 : w0;
    b_lo      = TWO_ONE - ({v0[FW-2:0], 1'b0} + v0);
    p12       = {1'b0, pt2, 3'b000} + {2'b00, pt2, 2'b00};
    num_lo    = (p12 >= {4'b0000, TWO_ONE}) ? '0 : FW'({4'b0000, TWO_ONE} - p12);
    num_next  = low2 ? (num_lo + FW'(1)) : ({pt2[FW-3:0], 2'b00} + FW'(1));
    quot_prod = {{FW{1'b0}}, num3} * {{FW{1'b0}}, RECIP};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      v0   <= v_in;
      w0   <= ONE - v_in;
      low0 <= v_in <= HALF;
      neg0 <= coord[COORD_W-1];
      out0 <= LW'(vabs) > LW'(ONE);
    end
    if (ctl.en[1]) begin
      sq1    <= fx_mul(a_sel, a_sel);
      maglo1 <= fx_mul(v0, b_lo);
      w1     <= w0;
      low1   <= low0;
      neg1   <= neg0;
      out1   <= out0;
    end
    if (ctl.en[2]) begin
      pt2  <= fx_mul(sq1, w1);
      mag2 <= low1 ? {maglo1[FW-3:0], 2'b00} : {sq1[FW-3:0], 2'b00};
      low2 <= low1;
      neg2 <= neg1;
      out2 <= out1;
    end
    if (ctl.en[3]) begin
      num3 <= num_next;
      mag3 <= mag2;
      neg3 <= neg2;
      out3 <= out2;
    end
    if (ctl.en[4]) begin
      val4 <= FW'(quot_prod >> (FW + 1));
      mag4 <= mag3;
      neg4 <= neg3;
      out4 <= out3;
    end
  end

  assign val     = val4;
  assign mag     = mag4;
  assign neg     = neg4;
  assign outside = out4;

endmodule

[design/cswg_combine.sv]
// ----------------------------------------------------------------------------
// cswg_combine
// Tensor-product stage: weight and gradient products over two register
// stages, zeroing and sign. The last stage is the output register.
// ----------------------------------------------------------------------------
module cswg_combine
  import cswg_pkg::*;
#(
  parameter int DIMS          = 3,
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  comb_ctl_t                         ctl,
  input  logic                              ena,
  input  logic [NUM_AXES-1:0][FRACTION_BITS+1:0] val,
  input  logic [NUM_AXES-1:0][FRACTION_BITS+1:0] mag,
  input  logic [NUM_AXES-1:0]               neg,
  input  logic [NUM_AXES-1:0]               outside,
  output logic [WEIGHT_W-1:0]               weight,
  output logic [GRAD_W-1:0]                 grad_x,
  output logic [GRAD_W-1:0]                 grad_y,
  output logic [GRAD_W-1:0]                 grad_z
);

  localparam int F  = FRACTION_BITS;
  localparam int FW = F + 2;

  localparam logic [2*FW-1:0] RND = {{(2*FW-1){1'b0}}, 1'b1} << (F - 1);

  function automatic logic [FW-1:0] fx_mul(input logic [FW-1:0] a, input logic [FW-1:0] b);
    logic [2*FW-1:0] p;
    p = {{FW{1'b0}}, a} * {{FW{1'b0}}, b} + RND;
    return p[F +: FW];
  endfunction

  function automatic logic [GRAD_W-1:0] apply_sign(input logic [FW-1:0] g, input logic n);
    logic [GRAD_W-1:0] gm;
    gm = GRAD_W'(g);
    return n ? gm : (~gm + 1'b1);
  endfunction

  logic [FW-1:0]       w_e, gx_e, gy_e, gz_e, v1_e, v2_e;
  logic [NUM_AXES-1:0] neg_e;
  logic                zero_e;

  logic [FW-1:0]       w_n, gx_n, gy_n, gz_n;
  logic [FW-1:0]       w_f, gx_f, gy_f, gz_f;

  always_comb begin
    if (DIMS >= 2) begin
      w_n  = fx_mul(val[0], val[1]);
      gx_n = fx_mul(mag[0], val[1]);
    end else begin
      w_n  = val[0];
      gx_n = mag[0];
    end
    gy_n = fx_mul(mag[1], val[0]);
    gz_n = fx_mul(mag[2], val[0]);

    if (DIMS >= 3) begin
      w_f  = fx_mul(w_e, v2_e);
      gx_f = fx_mul(gx_e, v2_e);
      gy_f = fx_mul(gy_e, v2_e);
    end else begin
      w_f  = w_e;
      gx_f = gx_e;
      gy_f = gy_e;
    end
    gz_f = fx_mul(gz_e, v1_e);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      w_e    <= w_n;
      gx_e   <= gx_n;
      gy_e   <= gy_n;
      gz_e   <= gz_n;
      v1_e   <= val[1];
      v2_e   <= val[2];
      neg_e  <= neg;
      zero_e <= !ena || (|outside);
    end
    if (ctl.en[1]) begin
      if (zero_e) begin
        weight <= '0;
        grad_x <= '0;
        grad_y <= '0;
        grad_z <= '0;
      end else begin
        weight <= WEIGHT_W'(w_f);
        grad_x <= apply_sign(gx_f, neg_e[0]);
        grad_y <= (DIMS >= 2) ? apply_sign(gy_f, neg_e[1]) : '0;
        grad_z <= (DIMS >= 3) ? apply_sign(gz_f, neg_e[2]) : '0;
      end
    end
  end

endmodule

[design/cubic_spline_weight_and_gradient.sv]
// ----------------------------------------------------------------------------
// cubic_spline_weight_and_gradient
// Tensor-product cubic B-spline weight and gradient, one point per cycle while m_tready allows.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ stream: s_tdata carries three Q2.16
//   coordinates, s_tuser the enable flag. Results leave on the m_ stream:
//   m_tdata carries the Q1.16 weight and three Q1.16 gradient components.
//   A disabled point, or one with any used axis beyond magnitude one,
//   gives an all-zero result.
//   The pipeline has seven register stages. A new request can enter
//   every cycle for a sustained rate of one point per clock while m_tready
//   stays high. The depth is set by the per-axis chain of square, cube
//   and divide by three as a reciprocal multiply, and the two product
//   stages across axes.
//   Each stage moves when its successor has room, so bubbles close up and
//   requests keep entering while a finished result waits. When m_tready
//   stays low the pipeline fills and s_tready falls; nothing is lost or
//   repeated. Synchronous reset clears all valid bits; the data and enable
//   registers are not reset.
// ----------------------------------------------------------------------------
module cubic_spline_weight_and_gradient
  import cswg_pkg::*;
#(
  parameter int DIMS          = 3,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z, zero pad
  input  logic                  s_tuser,   // enable
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // weight, grad_x, grad_y, grad_z, zero pad
);

  localparam int FW = FRACTION_BITS + 2;

  logic [NUM_STAGES-1:0]  vld;
  logic [NUM_STAGES-1:0]  en;
  logic [AXIS_STAGES-1:0] ena_pipe;

  axis_ctl_t axis_ctl;
  comb_ctl_t comb_ctl;

  logic [NUM_AXES-1:0][FW-1:0] val;
  logic [NUM_AXES-1:0][FW-1:0] mag;
  logic [NUM_AXES-1:0]         neg;
  logic [NUM_AXES-1:0]         outside;

  logic [WEIGHT_W-1:0] weight;
  logic [GRAD_W-1:0]   grad_x, grad_y, grad_z;

  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign axis_ctl.en = en[AXIS_STAGES-1:0];
  assign comb_ctl.en = en[NUM_STAGES-1:AXIS_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ena_pipe[0] <= s_tuser;
    end
    for (int k = 1; k < AXIS_STAGES; k++) begin
      if (en[k]) begin
        ena_pipe[k] <= ena_pipe[k-1];
      end
    end
  end

  for (genvar d = 0; d < NUM_AXES; d++) begin : g_axis
    if (d < DIMS) begin : g_used
      cswg_axis #(
        .FRACTION_BITS(FRACTION_BITS)
      ) u_axis (
        .clk     (clk),
        .ctl     (axis_ctl),
        .coord   (s_tdata[d*COORD_W +: COORD_W]),
        .val     (val[d]),
        .mag     (mag[d]),
        .neg     (neg[d]),
        .outside (outside[d])
      );
    end else begin : g_unused
      assign val[d]     = '0;
      assign mag[d]     = '0;
      assign neg[d]     = 1'b0;
      assign outside[d] = 1'b0;
    end
  end

  cswg_combine #(
    .DIMS          (DIMS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_combine (
    .clk     (clk),
    .ctl     (comb_ctl),
    .ena     (ena_pipe[AXIS_STAGES-1]),
    .val     (val),
    .mag     (mag),
    .neg     (neg),
    .outside (outside),
    .weight  (weight),
    .grad_x  (grad_x),
    .grad_y  (grad_y),
    .grad_z  (grad_z)
  );

  assign s_tready = en[0];
  assign m_tvalid = vld[NUM_STAGES-1];
  assign m_tdata  = {1'b0, grad_z, grad_y, grad_x, weight};

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted request did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or was dropped");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !m_tready |-> !s_tready)
    else $error("request taken while the pipeline is full and stalled");

  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (DIMS >= 3) || (grad_z == '0))
    else $error("unused axis gradient is not zero");

endmodule

[bench/cswg_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cswg_result_checker
// Watches both streams of the spline weight and gradient pipeline. Every
// accepted request is turned into the expected weight and gradient by a
// bit-exact fixed-point model of the spline. Every accepted result is compared
// with the oldest expected one. The mismatch count and the number of results
// still due go back to the bench top.
// ----------------------------------------------------------------------------
module cswg_result_checker
  import cswg_pkg::*;
#(
  parameter int DIMS          = 3,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // coord_x, coord_y, coord_z, zero pad
  input  logic                  s_tuser,   // enable
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // weight, grad_x, grad_y, grad_z, zero pad
  output int                    mismatches,
  output int                    pending
);

  localparam longint unsigned ONE_FX  = 64'd1 << FRACTION_BITS;
  localparam longint unsigned HALF_FX = 64'd1 << (FRACTION_BITS - 1);

  typedef struct packed {
    logic [GRAD_W-1:0]   grad_z;
    logic [GRAD_W-1:0]   grad_y;
    logic [GRAD_W-1:0]   grad_x;
    logic [WEIGHT_W-1:0] weight;
  } spline_result_t;

  spline_result_t results_due[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic longint unsigned round_mul(input longint unsigned a,
                                                input longint unsigned b);
    return (a * b + HALF_FX) >> FRACTION_BITS;
  endfunction

  // one axis: spline value and derivative magnitude, 0 when outside support
  function automatic bit axis_spline(input longint unsigned v,
                                     output longint unsigned val,
                                     output longint unsigned mag);
    longint unsigned w, p, w2;
    longint          n;
    val = 0;
    mag = 0;
    if (v > ONE_FX) return 1'b0;
    w = ONE_FX - v;
    if (v <= (ONE_FX >> 1)) begin
      p = round_mul(round_mul(v, v), w);
      n = longint'(2 * ONE_FX) - longint'(12 * p);
      if (n < 0) n = 0;
      val = (longint'(n) + 1) / 3;
      mag = 4 * round_mul(v, 2 * ONE_FX - 3 * v);
    end else begin
      w2  = round_mul(w, w);
      val = (4 * round_mul(w2, w) + 1) / 3;
      mag = 4 * w2;
    end
    return 1'b1;
  endfunction

  function automatic spline_result_t predict_spline(input logic [IN_DATA_W-1:0] data,
                                                    input logic enable);
    spline_result_t  res;
    longint unsigned vals[NUM_AXES];
    longint unsigned mags[NUM_AXES];
    bit              neg[NUM_AXES];
    longint          c;
    longint unsigned v, wgt, g;
    logic [GRAD_W-1:0] grads[NUM_AXES];
    res = '0;
    for (int d = 0; d < NUM_AXES; d++) begin
      vals[d]  = 0;
      mags[d]  = 0;
      neg[d]   = 1'b0;
      grads[d] = '0;
    end
    if (!enable) return res;
    for (int d = 0; d < NUM_AXES && d < DIMS; d++) begin
      c      = longint'($signed(data[d*COORD_W +: COORD_W]));
      neg[d] = c < 0;
      v      = longint'(c < 0 ? -c : c);
      if (!axis_spline(v, vals[d], mags[d])) return res;
    end
    wgt = vals[0];
    for (int d = 1; d < NUM_AXES && d < DIMS; d++) wgt = round_mul(wgt, vals[d]);
    res.weight = wgt[WEIGHT_W-1:0];
    for (int d = 0; d < NUM_AXES && d < DIMS; d++) begin
      g = mags[d];
      for (int i = 0; i < NUM_AXES && i < DIMS; i++)
        if (i != d) g = round_mul(g, vals[i]);
      // a positive coordinate slopes down
      if (!neg[d]) g = 64'd0 - g;
      grads[d] = g[GRAD_W-1:0];
    end
    res.grad_x = grads[0];
    res.grad_y = grads[1];
    res.grad_z = grads[2];
    return res;
  endfunction

  always @(posedge clk) begin
    spline_result_t want, got;
    if (!rst) begin
      if (s_tvalid && s_tready) results_due.push_back(predict_spline(s_tdata, s_tuser));
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(spline_result_t)-1:0];
        if (results_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result weight=%0d gx=%0d gy=%0d gz=%0d", $realtime,
                     got.weight, $signed(got.grad_x), $signed(got.grad_y),
                     $signed(got.grad_z));
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (got.weight !== want.weight || got.grad_x !== want.grad_x ||
              got.grad_y !== want.grad_y || got.grad_z !== want.grad_z) begin
            if (mismatches < 10)
              $display("%0t: mismatch exp w=%0d gx=%0d gy=%0d gz=%0d got w=%0d gx=%0d gy=%0d gz=%0d",
                       $realtime, want.weight, $signed(want.grad_x), $signed(want.grad_y),
                       $signed(want.grad_z), got.weight, $signed(got.grad_x),
                       $signed(got.grad_y), $signed(got.grad_z));
            mismatches++;
          end
        end
      end
      pending = results_due.size();
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream bench for the spline weight and gradient pipeline. Sends a directed
// set of edge points, then random points in three phases of sender and
// receiver stall rates, the last with none, drains between phases and
// gives the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_top
  import cswg_pkg::*;
();

  localparam int DIMS          = 3;
  localparam int FRACTION_BITS = 16;
  localparam int PHASE_ITEMS   = 250;
  localparam int CYCLE_LIMIT   = 200000;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int mismatches;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycles      = 0;

  always #1 clk = ~clk;

  cubic_spline_weight_and_gradient #(
    .DIMS          (DIMS),
    .FRACTION_BITS (FRACTION_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  cswg_result_checker #(
    .DIMS          (DIMS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_point(input int x, input int y, input int z, input bit en);
    logic [COORD_W-1:0] cx, cy, cz;
    cx = x[COORD_W-1:0];
    cy = y[COORD_W-1:0];
    cz = z[COORD_W-1:0];
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - 3*COORD_W){1'b0}}, cz, cy, cx};
    s_tuser  <= en;
    do @(posedge clk); while (!s_tready);
  endtask

  // sender holds off until every result is back
  task automatic drain;
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic int rand_coord();
    int sel, base;
    sel = $urandom_range(0, 9);
    case (sel) inside
      6: begin
        case ($urandom_range(0, 4))
          0: base = 0;
          1: base = 32768;
          2: base = -32768;
          3: base = 65536;
          default: base = -65536;
        endcase
        return base + int'($urandom_range(0, 6)) - 3;
      end
      7: return int'($urandom_range(0, 510)) - 255;
      [8:9]: return int'($urandom_range(0, 262144)) - 131072;
      default: return int'($urandom_range(0, 131072)) - 65536;
    endcase
  endfunction

  task automatic random_phase(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (PHASE_ITEMS)
      send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 9) != 0);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed edge points
    send_point(0, 0, 0, 1'b1);
    send_point(0, 0, 0, 1'b0);
    send_point(65536, 65536, 65536, 1'b1);
    send_point(-65536, -65536, -65536, 1'b1);
    send_point(32768, -32768, 32768, 1'b1);
    send_point(32769, -32767, 0, 1'b1);
    send_point(65537, 0, 0, 1'b1);
    send_point(0, -65537, 0, 1'b1);
    send_point(0, 0, 131072, 1'b1);
    send_point(-131072, -131072, -131072, 1'b1);
    send_point(131072, 131072, 131072, 1'b1);
    send_point(12345, -23456, 34567, 1'b0);
    send_point(1, -1, 1, 1'b1);
    send_point(21845, -21845, 21845, 1'b1);
    send_point(-1, 0, 65535, 1'b1);
    send_point(40000, -50000, 60000, 1'b1);
    send_point(65536, 0, -32768, 1'b1);
    send_point(-32768, 65535, 1, 1'b1);
    send_point(-65536, 65536, -1, 1'b0);
    drain();

    random_phase(32, 60);
    random_phase(60, 32);
    random_phase(0, 0);

    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
design/cswg_pkg.sv
design/cswg_axis.sv
design/cswg_combine.sv
design/cubic_spline_weight_and_gradient.sv
bench/cswg_result_checker.sv
bench/tb_top.sv
